// ===== rtl/ffsa_pkg.sv =====
// Shared types and constants of the first-fit segment allocator.
`default_nettype none
package ffsa_pkg;

  localparam int unsigned MaxSegments = 64;
  localparam int unsigned OwnerBits   = 8;
  localparam int unsigned IdxW        = $clog2(MaxSegments);
  localparam int unsigned CntW        = $clog2(MaxSegments + 1);
  localparam int unsigned AddrW       = 16;

  localparam logic [CntW-1:0] MaxCount = CntW'(MaxSegments);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD,
    S_CHK,
    S_SH_RD,
    S_SH_WR,
    S_WR_REM,
    S_WR_OWN,
    S_R_RD,
    S_R_CHK,
    S_L_RD,
    S_L_CHK,
    S_RESP
  } state_e;

  // One segment table entry.
  typedef struct packed {
    logic                 free;
    logic [OwnerBits-1:0] owner;
    logic [AddrW-1:0]     start;
    logic [AddrW-1:0]     length;
  } seg_t;

  // Result word handed to the output register.
  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] start_addr;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/ffsa_req_if.sv =====
// Channel interfaces for requests, results and the heap size register.
`default_nettype none
interface ffsa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  owner_id;
  logic [15:0] alloc_size;
  logic [15:0] free_start;
  modport source (output valid, req_type, owner_id, alloc_size, free_start, input ready);
  modport sink   (input valid, req_type, owner_id, alloc_size, free_start, output ready);
endinterface

interface ffsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] start_addr;
  modport source (output valid, status, start_addr, input ready);
  modport sink   (input valid, status, start_addr, output ready);
endinterface

interface ffsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ffsa_out_reg.sv =====
// Output register that holds one result word until the sink takes it.
`default_nettype none
module ffsa_out_reg
  import ffsa_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire rsp_t     rsp_i,
  output logic          free_o,
  ffsa_rsp_if.source    rsp_o
);

  logic valid_q, valid_d;
  rsp_t data_q;

  // The slot is free when empty or when the held word leaves this cycle.
  assign free_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= rsp_i;
    end
  end

  assign rsp_o.valid      = valid_q;
  assign rsp_o.status     = data_q.status;
  assign rsp_o.start_addr = data_q.start_addr;

endmodule
`default_nettype wire

// ===== rtl/first_fit_segment_allocator.sv =====
// Top level: segment table memory with its scan, shift and merge sequencer.
// An item scans the table segment by segment to find its entry; a split or merge then
// shifts the later entries by one place, each moved by a read and a write. One item at a time.
// The simple dual-port table memory (one read, one write a cycle) limits scan and shift speed.
// Reset and each heap size write pass through S_INIT, which writes the initial free segment.
`default_nettype none
module first_fit_segment_allocator
  import ffsa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ffsa_cfg_if.sink   cfg_i,
  ffsa_req_if.sink   req_i,
  ffsa_rsp_if.source rsp_o
);

  // Segment table memory.
  seg_t seg_mem [MaxSegments];
  seg_t rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  seg_t            mem_wdata;
  logic [IdxW-1:0] mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= seg_mem[mem_raddr];
  end

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic [AddrW-1:0] heap_q, heap_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  dst_q, dst_d;
  logic [CntW-1:0]  lim_q, lim_d;
  logic             up_q, up_d;
  seg_t             cur_q, cur_d;
  logic             rtype_q;
  logic [OwnerBits-1:0] owner_q;
  logic [AddrW-1:0] size_q, fstart_q;
  rsp_t             res_q, res_d;

  logic out_free;
  logic req_acc, cfg_acc;
  logic sh_more;
  logic [CntW-1:0] sh_src;

  assign req_acc = req_i.valid && req_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  // Shift engine: keep moving while the destination has not reached its bound.
  assign sh_more = up_q ? (dst_q > lim_q) : ((dst_q + CntW'(1)) < cnt_q);
  assign sh_src  = up_q ? (dst_q - CntW'(1)) : (dst_q + CntW'(1));

  // Next state and register updates.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    heap_d  = heap_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    dst_d   = dst_q;
    lim_d   = lim_q;
    up_d    = up_q;
    cur_d   = cur_q;
    res_d   = res_q;
    case (state_q)
      S_INIT: begin
        cnt_d   = CntW'(1);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_acc) begin
          heap_d  = cfg_i.data;
          state_d = S_INIT;
        end else if (req_acc) begin
          idx_d = '0;
          res_d = '{status: ST_MISS, start_addr: '0};
          if (req_e'(req_i.req_type) == REQ_ALLOC && req_i.alloc_size == '0) begin
            state_d = S_RESP;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_q >= cnt_q) begin
          state_d = S_RESP;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        state_d = S_RD;
        idx_d   = idx_q + CntW'(1);
        if (req_e'(rtype_q) == REQ_ALLOC) begin
          if (rdata_q.free && rdata_q.length >= size_q) begin
            idx_d = idx_q;
            if (rdata_q.length == size_q) begin
              res_d   = '{status: ST_OK, start_addr: rdata_q.start};
              state_d = S_RESP;
            end else if (cnt_q >= MaxCount) begin
              res_d   = '{status: ST_FULL, start_addr: '0};
              state_d = S_RESP;
            end else begin
              cur_d   = rdata_q;
              up_d    = 1'b1;
              dst_d   = cnt_q;
              lim_d   = idx_q + CntW'(1);
              ret_d   = S_WR_REM;
              state_d = S_SH_RD;
            end
          end
        end else begin
          if (!rdata_q.free && rdata_q.owner == owner_q && rdata_q.start == fstart_q) begin
            idx_d   = idx_q;
            cur_d   = '{free: 1'b1, owner: '0, start: rdata_q.start,
                        length: rdata_q.length};
            res_d   = '{status: ST_OK, start_addr: '0};
            state_d = S_R_RD;
          end
        end
      end
      S_SH_RD: begin
        if (sh_more) begin
          state_d = S_SH_WR;
        end else begin
          if (!up_q) begin
            cnt_d = cnt_q - CntW'(1);
          end
          state_d = ret_q;
        end
      end
      S_SH_WR: begin
        dst_d   = up_q ? (dst_q - CntW'(1)) : (dst_q + CntW'(1));
        state_d = S_SH_RD;
      end
      S_WR_REM: begin
        state_d = S_WR_OWN;
      end
      S_WR_OWN: begin
        cnt_d   = cnt_q + CntW'(1);
        res_d   = '{status: ST_OK, start_addr: cur_q.start};
        state_d = S_RESP;
      end
      S_R_RD: begin
        if ((idx_q + CntW'(1)) < cnt_q) begin
          state_d = S_R_CHK;
        end else begin
          state_d = S_L_RD;
        end
      end
      S_R_CHK: begin
        if (rdata_q.free) begin
          cur_d.length = cur_q.length + rdata_q.length;
          up_d    = 1'b0;
          dst_d   = idx_q + CntW'(1);
          ret_d   = S_L_RD;
          state_d = S_SH_RD;
        end else begin
          state_d = S_L_RD;
        end
      end
      S_L_RD: begin
        if (idx_q != '0) begin
          state_d = S_L_CHK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_L_CHK: begin
        if (rdata_q.free) begin
          up_d    = 1'b0;
          dst_d   = idx_q;
          ret_d   = S_RESP;
          state_d = S_SH_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  // Memory access and handshake outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q[IdxW-1:0];
    mem_wdata = cur_q;
    mem_raddr = idx_q[IdxW-1:0];
    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{free: 1'b1, owner: '0, start: '0, length: heap_q};
      end
      S_CHK: begin
        if (req_e'(rtype_q) == REQ_ALLOC && rdata_q.free && rdata_q.length == size_q) begin
          mem_we    = 1'b1;
          mem_wdata = '{free: 1'b0, owner: owner_q, start: rdata_q.start,
                        length: rdata_q.length};
        end
      end
      S_SH_RD: begin
        mem_raddr = sh_src[IdxW-1:0];
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_q[IdxW-1:0];
        mem_wdata = rdata_q;
      end
      S_WR_REM: begin
        mem_we    = 1'b1;
        mem_waddr = lim_q[IdxW-1:0];
        mem_wdata = '{free: 1'b1, owner: '0, start: cur_q.start + size_q,
                      length: cur_q.length - size_q};
      end
      S_WR_OWN: begin
        mem_we    = 1'b1;
        mem_wdata = '{free: 1'b0, owner: owner_q, start: cur_q.start, length: size_q};
      end
      S_R_RD: begin
        mem_raddr = idx_q[IdxW-1:0] + IdxW'(1);
      end
      S_L_RD: begin
        mem_raddr = idx_q[IdxW-1:0] - IdxW'(1);
        if (idx_q == '0) begin
          mem_we = 1'b1;
        end
      end
      S_L_CHK: begin
        mem_we = 1'b1;
        if (rdata_q.free) begin
          mem_waddr = idx_q[IdxW-1:0] - IdxW'(1);
          mem_wdata = '{free: 1'b1, owner: rdata_q.owner, start: rdata_q.start,
                        length: rdata_q.length + cur_q.length};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign cfg_i.ready = (state_q == S_IDLE);
  assign req_i.ready = (state_q == S_IDLE) && !cfg_i.valid;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      ret_q   <= S_RESP;
      heap_q  <= '1;
      cnt_q   <= CntW'(1);
      idx_q   <= '0;
      dst_q   <= '0;
      lim_q   <= '0;
      up_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      heap_q  <= heap_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      dst_q   <= dst_d;
      lim_q   <= lim_d;
      up_q    <= up_d;
    end
  end

  // Request word and working entry.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    if (req_acc) begin
      rtype_q  <= req_i.req_type;
      owner_q  <= req_i.owner_id[OwnerBits-1:0];
      size_q   <= req_i.alloc_size;
      fstart_q <= req_i.free_start;
    end
  end

  ffsa_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (state_q == S_RESP && out_free),
    .rsp_i  (res_q),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire
